// ===== hw/rtl/hdbn_pkg.sv =====
// shared types and constants for the hdbn line encoder
package hdbn_pkg;

    // one line symbol, bit 0 positive pulse, bit 1 negative pulse
    typedef logic [1:0] t_sym;

    localparam t_sym SYM_SPACE = 2'b00;
    localparam t_sym SYM_POS   = 2'b01;
    localparam t_sym SYM_NEG   = 2'b10;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ZERO_RUN_LIMIT  = 2'd0;
    localparam t_cfg_idx CFG_START_POSITIVE  = 2'd1;
    localparam t_cfg_idx CFG_FIRST_VIOL_NEG  = 2'd2;

    localparam int CFG_DATA_W = 3;

    // reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] RST_ZERO_RUN_LIMIT = 3'd3;
    localparam logic                  RST_START_POSITIVE = 1'b1;
    localparam logic                  RST_FIRST_VIOL_NEG = 1'b1;

    // pulse symbol of the given polarity
    function automatic t_sym pulse_sym(input logic positive);
        return positive ? SYM_POS : SYM_NEG;
    endfunction

endpackage

// ===== hw/rtl/hdbn_line_encoder_unit.sv =====
// top level of the hdbn line encoder
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------------
//  s        | in        | i_s_tvalid / o_s_tready    | tdata[0] data bit, tuser start,
//           |           |                            | tlast end of message
//  m        | out       | o_m_tvalid / i_m_tready    | tdata[0] pos, tdata[1] neg,
//           |           |                            | tlast last symbol of the item
//  cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// an item is coded in the cycle it is accepted; its 0 to MAX_RUN+1 symbols then
// leave the result register one per cycle while the output is ready, so a one-symbol
// item stream runs at one item per cycle and a longer burst holds the input off.
// a new item is taken in the cycle the last symbol of the previous burst is taken.
// reset is synchronous; it clears the line state and loads the register defaults.
// configuration writes are always ready; the input is held off while one is offered.
module hdbn_line_encoder_unit import hdbn_pkg::*; #(
    parameter int MAX_RUN = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [0] data_bit, [7:1] zero
    input  logic                  i_s_tuser,   // [0] start_of_message
    input  logic                  i_s_tlast,   // end_of_message
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [0] pos_pulse, [1] neg_pulse, [7:2] zero
    output logic                  o_m_tlast,   // last_of_run
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_RUN + 2);

    logic                  accept;
    logic                  load_ready;
    logic [MAX_RUN:0][1:0] burst_sym;
    logic [CW-1:0]         burst_len;
    t_sym                  out_sym;

    // a register write and an item never land on the same edge
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = load_ready && !i_cfg_valid;
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_m_tdata   = {6'b0, out_sym};

    // line state and symbol burst
    hdbn_coder #(
        .MAX_RUN (MAX_RUN),
        .CW      (CW)
    ) u_coder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_bit  (i_s_tdata[0]),
        .i_start     (i_s_tuser),
        .i_end       (i_s_tlast),
        .o_burst_sym (burst_sym),
        .o_burst_len (burst_len)
    );

    // result register
    hdbn_burst_buf #(
        .MAX_RUN (MAX_RUN),
        .CW      (CW)
    ) u_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_burst_sym  (burst_sym),
        .i_burst_len  (burst_len),
        .o_load_ready (load_ready),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_sym        (out_sym),
        .o_last       (o_m_tlast)
    );

endmodule

// ===== hw/rtl/hdbn_coder.sv =====
// encoder core: configuration, line state and symbol burst for one item
module hdbn_coder import hdbn_pkg::*; #(
    parameter int MAX_RUN = 4,
    parameter int CW      = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  t_cfg_idx                i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_accept,
    input  logic                    i_data_bit,
    input  logic                    i_start,
    input  logic                    i_end,
    output logic [MAX_RUN:0][1:0]   o_burst_sym,
    output logic [CW-1:0]           o_burst_len
);

    localparam int NW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] r_limit;
    logic                  r_start_pos;
    logic                  r_last_pos, n_last_pos;
    logic                  r_viol_neg, n_viol_neg;
    logic [CW-1:0]         r_zc, n_zc;

    logic [NW-1:0]         limit_ext;
    logic [CW-1:0]         run_n;
    logic                  lp0;
    logic [CW-1:0]         zc0, zc1, excess, viol_at;
    logic                  subst, vp;

    // clamp the run limit into its legal range
    always_comb begin
        limit_ext = NW'(r_limit);
        if (limit_ext < NW'(2)) begin
            run_n = CW'(2);
        end else if (limit_ext > NW'(MAX_RUN)) begin
            run_n = CW'(MAX_RUN);
        end else begin
            run_n = limit_ext[CW-1:0];
        end
    end

    // burst build and next line state
    always_comb begin
        lp0     = i_start ? ~r_start_pos : r_last_pos;
        zc0     = i_start ? '0 : r_zc;
        zc1     = zc0 + CW'(1);
        vp      = ~r_viol_neg;
        subst   = (zc1 >= run_n + CW'(1));
        excess  = zc1 - (run_n + CW'(1));
        viol_at = excess + run_n;
        n_last_pos  = lp0;
        n_viol_neg  = r_viol_neg;
        n_zc        = zc1;
        o_burst_len = '0;
        o_burst_sym = '0;
        if (i_data_bit) begin
            // held zeros go out as spaces, then the alternate pulse
            n_last_pos  = ~lp0;
            n_zc        = '0;
            o_burst_len = zc0 + CW'(1);
            for (int i = 0; i <= MAX_RUN; i++) begin
                if (CW'(i) == zc0) begin
                    o_burst_sym[i] = pulse_sym(~lp0);
                end else begin
                    o_burst_sym[i] = SYM_SPACE;
                end
            end
        end else if (subst) begin
            // substitution group after any excess zeros
            n_last_pos  = vp;
            n_viol_neg  = ~r_viol_neg;
            n_zc        = '0;
            o_burst_len = zc1;
            for (int i = 0; i <= MAX_RUN; i++) begin
                if (CW'(i) == excess && lp0 != vp) begin
                    o_burst_sym[i] = pulse_sym(vp);
                end else if (CW'(i) == viol_at) begin
                    o_burst_sym[i] = pulse_sym(vp);
                end else begin
                    o_burst_sym[i] = SYM_SPACE;
                end
            end
        end else if (i_end) begin
            // end of message flushes held zeros as plain spaces
            n_zc        = '0;
            o_burst_len = zc1;
        end
    end

    // configuration and line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= RST_ZERO_RUN_LIMIT;
            r_start_pos <= RST_START_POSITIVE;
            r_last_pos  <= ~RST_START_POSITIVE;
            r_viol_neg  <= RST_FIRST_VIOL_NEG;
            r_zc        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ZERO_RUN_LIMIT: begin
                    r_limit <= i_cfg_data;
                end
                CFG_START_POSITIVE: begin
                    r_start_pos <= i_cfg_data[0];
                    r_last_pos  <= ~i_cfg_data[0];
                end
                CFG_FIRST_VIOL_NEG: begin
                    r_viol_neg <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            r_last_pos <= n_last_pos;
            r_viol_neg <= n_viol_neg;
            r_zc       <= n_zc;
        end
    end

endmodule

// ===== hw/rtl/hdbn_burst_buf.sv =====
// result register: holds one symbol burst and releases it a symbol per cycle while the output is ready
module hdbn_burst_buf import hdbn_pkg::*; #(
    parameter int MAX_RUN = 4,
    parameter int CW      = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [MAX_RUN:0][1:0]   i_burst_sym,
    input  logic [CW-1:0]           i_burst_len,
    output logic                    o_load_ready,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_sym                    o_sym,
    output logic                    o_last
);

    logic [MAX_RUN:0][1:0] r_sym, n_sym;
    logic [CW-1:0]         r_left, n_left;
    logic                  pop;

    assign o_valid      = (r_left != '0);
    assign pop          = o_valid && i_ready;
    assign o_sym        = r_sym[0];
    assign o_last       = (r_left == CW'(1));
    assign o_load_ready = (r_left == '0) || (o_last && i_ready);

    // shift out on a pop, reload on an item with symbols
    always_comb begin
        n_sym  = r_sym;
        n_left = r_left;
        if (pop) begin
            for (int i = 0; i < MAX_RUN; i++) begin
                n_sym[i] = r_sym[i+1];
            end
            n_sym[MAX_RUN] = SYM_SPACE;
            n_left         = r_left - CW'(1);
        end
        if (i_load && i_burst_len != '0) begin
            n_sym  = i_burst_sym;
            n_left = i_burst_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
    end

endmodule

// ===== hw/rtl/hdbn_checker.sv =====
// port-level checks for the hdbn line encoder
module hdbn_checker import hdbn_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [7:0]            i_s_tdata,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [7:0]            o_m_tdata,
    input logic                  o_m_tlast
);

    // a stalled symbol stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output item dropped while stalled");

    // a stalled symbol keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output item changed while stalled");

    // a symbol is never both polarities
    a_one_polarity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("symbol with both pulses");

    // an accepted one always yields a symbol in the next cycle
    a_one_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tdata[0] |=> o_m_tvalid)
        else $error("accepted one gave no symbol");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind hdbn_line_encoder_unit hdbn_checker u_hdbn_checker (.*);

// ===== verif/tb_hdbn_line_encoder_unit.sv =====
// testbench for the hdbn line encoder: directed table, random messages, line-code predictor
module tb_hdbn_line_encoder_unit;
    import hdbn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RUN        = 4;
    localparam int CLK_HALF       = 10;
    localparam int DRAIN          = MAX_RUN + 4;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 60;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int MAX_REPORTS    = 40;
    localparam int PREDICTED      = -1;

    // index that decodes to no register
    localparam t_cfg_idx CFG_UNUSED_IDX = 2'd3;

    // limit values swept by the random phases, phase 0 in the low bits
    localparam logic [23:0] LIMIT_SWEEP =
        {3'd6, 3'd5, 3'd1, 3'd3, 3'd7, 3'd0, 3'd4, 3'd2};

    // typed expectations, oldest symbol in the low bits
    localparam logic [11:0] NOTHING       = 12'd0;
    localparam logic [11:0] ONE_POS       = {10'd0, SYM_POS};
    localparam logic [11:0] ONE_NEG       = {10'd0, SYM_NEG};
    localparam logic [11:0] ONE_SPACE     = {10'd0, SYM_SPACE};
    localparam logic [11:0] SUB_PLAIN_NEG = {4'd0, SYM_NEG, SYM_SPACE, SYM_SPACE, SYM_SPACE};
    localparam logic [11:0] SUB_BAL_POS   = {4'd0, SYM_POS, SYM_SPACE, SYM_SPACE, SYM_POS};

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
    typedef enum logic [1:0] {SINK_FREE, SINK_COIN, SINK_PATTERN, SINK_SLUGGISH} sink_mode_e;

    typedef struct {
        row_kind_e               kind;
        t_cfg_idx                idx;
        logic [CFG_DATA_W-1:0]   cfg_val;
        logic                    d;
        logic                    som;
        logic                    eom;
        int                      n_typed;
        logic [11:0]             typed;
    } plan_row_t;

    typedef struct packed {
        t_sym sym;
        logic last;
    } line_sym_t;

    // directed sequence, reset config first: n = 3, first pulse positive, violation negative
    plan_row_t plan [28] = '{
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b1, 1'b1, 1'b0, 1, ONE_POS},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b1, 1'b0, 1'b0, 1, ONE_NEG},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, 0, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, 0, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, 0, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, 4, SUB_PLAIN_NEG},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, 0, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, 0, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, 0, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, 4, SUB_BAL_POS},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b1, 1'b0, 1'b0, PREDICTED, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b1, 1, ONE_SPACE},
        // start inside a run drops the held zero
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b1, 1'b0, PREDICTED, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b1, 1'b1, 1'b0, 1, ONE_POS},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b1, 1'b1, 1'b1, 1, ONE_POS},
        // message that opens with a full zero run
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b1, 1'b0, PREDICTED, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, PREDICTED, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, PREDICTED, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, PREDICTED, NOTHING},
        // limit clamped high, then lowered below the held run and clamped low
        '{ROW_CFG,  CFG_ZERO_RUN_LIMIT, 3'd7, 1'b0, 1'b0, 1'b0, PREDICTED, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, PREDICTED, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, PREDICTED, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, PREDICTED, NOTHING},
        '{ROW_CFG,  CFG_ZERO_RUN_LIMIT, 3'd1, 1'b0, 1'b0, 1'b0, PREDICTED, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b0, 1'b0, 1'b0, PREDICTED, NOTHING},
        // negative start and positive first violation, upper data bits set
        '{ROW_CFG,  CFG_START_POSITIVE, 3'b110, 1'b0, 1'b0, 1'b0, PREDICTED, NOTHING},
        '{ROW_CFG,  CFG_FIRST_VIOL_NEG, 3'b100, 1'b0, 1'b0, 1'b0, PREDICTED, NOTHING},
        '{ROW_ITEM, CFG_ZERO_RUN_LIMIT, 3'd0, 1'b1, 1'b1, 1'b0, 1, ONE_NEG}
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata   = 8'd0;   // [0] data_bit, [7:1] zero
    logic                  i_s_tuser   = 1'b0;   // [0] start_of_message
    logic                  i_s_tlast   = 1'b0;   // end_of_message
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [7:0]            o_m_tdata;            // [0] pos_pulse, [1] neg_pulse, [7:2] zero
    logic                  o_m_tlast;            // last_of_run
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = CFG_ZERO_RUN_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // predictor copy of registers and line state
    logic [CFG_DATA_W-1:0] run_limit_reg;
    logic                  start_pos_reg;
    logic                  last_pos;
    logic                  viol_neg;
    int                    zeros_held;

    line_sym_t symbols_due [$];
    t_sym      coded_syms [$];
    int        mismatches  = 0;
    int        items_sent  = 0;
    int        burst_left  = 0;
    bit        holdoff_req  = 1'b0;
    bit        holdoff_done = 1'b0;

    hdbn_line_encoder_unit #(
        .MAX_RUN (MAX_RUN)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // hdbn coding of one bit, symbols left in coded_syms in line order
    task automatic hdbn_code_bit(input logic d, input logic som, input logic eom);
        int   n;
        logic viol_pos;
        coded_syms.delete();
        n = run_limit_reg;
        if (n < 2) n = 2;
        if (n > MAX_RUN) n = MAX_RUN;
        if (som) begin
            last_pos   = ~start_pos_reg;
            zeros_held = 0;
        end
        if (d) begin
            repeat (zeros_held) coded_syms.push_back(SYM_SPACE);
            last_pos = ~last_pos;
            coded_syms.push_back(last_pos ? SYM_POS : SYM_NEG);
            zeros_held = 0;
        end else begin
            zeros_held++;
            // run complete: excess zeros plain, then balancing slot, spaces, violation
            if (zeros_held >= n + 1) begin
                viol_pos = ~viol_neg;
                repeat (zeros_held - (n + 1)) coded_syms.push_back(SYM_SPACE);
                if (last_pos == viol_pos) begin
                    coded_syms.push_back(SYM_SPACE);
                end else begin
                    coded_syms.push_back(viol_pos ? SYM_POS : SYM_NEG);
                    last_pos = viol_pos;
                end
                repeat (n - 1) coded_syms.push_back(SYM_SPACE);
                coded_syms.push_back(viol_pos ? SYM_POS : SYM_NEG);
                viol_neg   = ~viol_neg;
                zeros_held = 0;
            end
        end
        if (eom) begin
            repeat (zeros_held) coded_syms.push_back(SYM_SPACE);
            zeros_held = 0;
        end
    endtask

    // offer one item in bursts with random gaps, then queue its symbols
    task automatic send_item(input logic d, input logic som, input logic eom,
                             input int n_typed, input logic [11:0] typed);
        int        gap;
        line_sym_t entry;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            repeat (gap) begin
                i_s_tvalid = 1'b0;
                i_s_tdata  = {7'd0, 1'($urandom_range(0, 1))};
                i_s_tuser  = 1'($urandom_range(0, 1));
                i_s_tlast  = 1'($urandom_range(0, 1));
                @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tdata  = {7'd0, d};
        i_s_tuser  = som;
        i_s_tlast  = eom;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        hdbn_code_bit(d, som, eom);
        if (n_typed == PREDICTED) begin
            foreach (coded_syms[s]) begin
                entry.sym  = coded_syms[s];
                entry.last = (s == coded_syms.size() - 1);
                symbols_due.push_back(entry);
            end
        end else begin
            for (int s = 0; s < n_typed; s++) begin
                entry.sym  = typed[2*s +: 2];
                entry.last = (s == n_typed - 1);
                symbols_due.push_back(entry);
            end
        end
    endtask

    // stop offering, let every queued symbol out, then wait out the pipeline
    task automatic wait_line_idle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        burst_left = 0;
        while (symbols_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ZERO_RUN_LIMIT: run_limit_reg = val;
            CFG_START_POSITIVE: begin
                start_pos_reg = val[0];
                last_pos      = ~val[0];
            end
            CFG_FIRST_VIOL_NEG: viol_neg = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // message with random zero runs; a broken one may lose or gain its markers
    task automatic send_message(input int len, input bit broken);
        int   zeros_left;
        logic d;
        logic som;
        logic eom;
        zeros_left = 0;
        for (int i = 0; i < len; i++) begin
            if (zeros_left > 0) begin
                d = 1'b0;
                zeros_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                d = 1'b0;
                zeros_left = $urandom_range(0, 6);
            end else begin
                d = 1'b1;
            end
            som = (i == 0);
            eom = (i == len - 1);
            if (broken && $urandom_range(0, 3) == 0) som = ~som;
            if (broken && $urandom_range(0, 3) == 0) eom = ~eom;
            send_item(d, som, eom, PREDICTED, NOTHING);
        end
    endtask

    // compare each symbol taken from the block with the oldest expectation
    always @(posedge i_clk) begin : line_check
        line_sym_t due;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (symbols_due.size() == 0) begin
                flag_mismatch($sformatf("symbol %b%b with nothing expected",
                                        o_m_tdata[1], o_m_tdata[0]));
            end else begin
                due = symbols_due.pop_front();
                if (o_m_tdata[0] !== due.sym[0]) begin
                    flag_mismatch($sformatf("pos_pulse %b, expected %b",
                                            o_m_tdata[0], due.sym[0]));
                end
                if (o_m_tdata[1] !== due.sym[1]) begin
                    flag_mismatch($sformatf("neg_pulse %b, expected %b",
                                            o_m_tdata[1], due.sym[1]));
                end
                if (o_m_tlast !== due.last) begin
                    flag_mismatch($sformatf("last_of_run %b, expected %b",
                                            o_m_tlast, due.last));
                end
            end
        end
    end

    // receiver: stretches of different stall patterns, one long hold-off on request
    initial begin : line_sink
        sink_mode_e mode;
        int         stretch;
        int         beat;
        int         held;
        stretch = 0;
        beat    = 0;
        held    = 0;
        mode    = SINK_FREE;
        forever begin
            @(negedge i_clk);
            if (holdoff_req && !holdoff_done) begin
                i_m_tready = 1'b0;
                held++;
                if (held >= HOLDOFF_CYCLES) holdoff_done = 1'b1;
            end else begin
                if (stretch == 0) begin
                    mode    = sink_mode_e'($urandom_range(0, 3));
                    stretch = $urandom_range(10, 80);
                end
                stretch--;
                beat++;
                case (mode)
                    SINK_FREE:     i_m_tready = 1'b1;
                    SINK_COIN:     i_m_tready = 1'($urandom_range(0, 1));
                    SINK_PATTERN:  i_m_tready = (beat % 5) < 3;
                    SINK_SLUGGISH: i_m_tready = ($urandom_range(0, 3) == 0);
                    default:       i_m_tready = 1'b1;
                endcase
            end
        end
    end

    // main sequence
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] reg_val;
        int                    phase_end;
        int                    pick;
        run_limit_reg = RST_ZERO_RUN_LIMIT;
        start_pos_reg = RST_START_POSITIVE;
        last_pos      = ~RST_START_POSITIVE;
        viol_neg      = RST_FIRST_VIOL_NEG;
        zeros_held    = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                wait_line_idle();
                write_reg(plan[r].idx, plan[r].cfg_val);
            end else begin
                send_item(plan[r].d, plan[r].som, plan[r].eom, plan[r].n_typed, plan[r].typed);
            end
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_line_idle();
            write_reg(CFG_ZERO_RUN_LIMIT, LIMIT_SWEEP[3*phase +: 3]);
            reg_val    = CFG_DATA_W'($urandom);
            reg_val[0] = phase[0];
            write_reg(CFG_START_POSITIVE, reg_val);
            reg_val    = CFG_DATA_W'($urandom);
            reg_val[0] = phase[1];
            write_reg(CFG_FIRST_VIOL_NEG, reg_val);
            if (phase == 5) write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
            if (phase == 2) holdoff_req = 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    send_message($urandom_range(2, 24), pick == 7);
                end else begin
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), PREDICTED, NOTHING);
                end
            end
        end

        wait_line_idle();
        if (mismatches == 0) begin
            $display("hdbn_line_encoder_unit verification clean");
        end else begin
            $display("hdbn_line_encoder_unit verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("hdbn_line_encoder_unit verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hdbn_pkg.sv
hw/rtl/hdbn_coder.sv
hw/rtl/hdbn_burst_buf.sv
hw/rtl/hdbn_line_encoder_unit.sv
hw/rtl/hdbn_checker.sv
verif/tb_hdbn_line_encoder_unit.sv
